>>> sv/mil_pkg.sv
// Package for the movie input line parser.
// Holds the line phase encoding, result status codes, register indexes and
// the parser-to-output result struct. No dependencies.
`default_nettype none

package mil_pkg;

   // Configuration port geometry
   localparam int unsigned CsrIndexBits = 2;
   localparam int unsigned CsrDataBits  = 16;

   // Register indexes
   localparam logic [CsrIndexBits-1:0] CSR_SKIP_RECORDS = 2'd0;
   localparam logic [CsrIndexBits-1:0] CSR_PORT_COUNT   = 2'd1;

   // Fixed field widths
   localparam int unsigned SkipBits      = 16;
   localparam int unsigned PortCountBits = 3;
   localparam int unsigned PortIdxBits   = 3;
   localparam int unsigned CharBits      = 8;
   localparam int unsigned StatusBits    = 2;
   localparam int unsigned PortOutBits   = 2;
   localparam int unsigned ButtonOutBits = 8;

   // Characters of interest
   localparam logic [CharBits-1:0] CH_BAR   = 8'h7C;
   localparam logic [CharBits-1:0] CH_DOT   = 8'h2E;
   localparam logic [CharBits-1:0] CH_SPACE = 8'h20;
   localparam logic [CharBits-1:0] CH_CR    = 8'h0D;
   localparam logic [CharBits-1:0] CH_LF    = 8'h0A;
   localparam logic [CharBits-1:0] CH_ZERO  = 8'h30;
   localparam logic [CharBits-1:0] CH_NINE  = 8'h39;

   // Result status codes
   typedef enum logic [StatusBits-1:0] {
      ST_OK     = 2'd0,
      ST_BADSEP = 2'd1,
      ST_UNTERM = 2'd2,
      ST_PORTS  = 2'd3
   } status_type;

   // Line phase, one-hot
   typedef enum logic [3:0] {
      PH_START  = 4'b0001,
      PH_IGNORE = 4'b0010,
      PH_DIGITS = 4'b0100,
      PH_FIELDS = 4'b1000
   } phase_type;

   // One result item from the parser
   typedef struct packed {
      logic                     valid;
      status_type               status;
      logic [PortOutBits-1:0]   port;
      logic [ButtonOutBits-1:0] buttons;
   } result_type;

endpackage

`default_nettype wire

>>> sv/mil_parser.sv
// Line parser state and per-character update for the movie input parser.
// Uses mil_pkg for phase, status and result types.
`default_nettype none

module mil_parser #(
   parameter int unsigned MAX_PORTS   = 4,
   parameter int unsigned BUTTON_BITS = 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              step,
   input  wire logic [mil_pkg::CharBits-1:0]      char_in,
   input  wire logic [mil_pkg::PortCountBits-1:0] port_count,
   input  wire logic                              skip_load,
   input  wire logic [mil_pkg::SkipBits-1:0]      skip_value,
   output mil_pkg::result_type                    result
);
   import mil_pkg::*;

   localparam logic [PortCountBits:0] MaxPortsW = (PortCountBits + 1)'(MAX_PORTS);

   phase_type                line_phase_ff, line_phase_in;
   logic [SkipBits-1:0]      skip_ff, skip_in;
   logic [PortIdxBits-1:0]   port_index_ff, port_index_in;
   logic [BUTTON_BITS-1:0]   shifter_ff, shifter_in;
   logic                     field_open_ff, field_open_in;

   logic                     eol;
   logic                     is_digit;
   logic                     char_bit;
   logic [PortCountBits:0]   limit;
   logic                     over_limit;
   logic [31:0]              shifter_wide;

   // Character classes and port limit
   assign eol        = (char_in == CH_CR) || (char_in == CH_LF);
   assign is_digit   = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
   assign char_bit   = !((char_in == CH_DOT) || (char_in == CH_SPACE));
   assign limit      = ({1'b0, port_count} < MaxPortsW) ? {1'b0, port_count} : MaxPortsW;
   assign over_limit = ({1'b0, port_index_ff} >= limit);
   assign shifter_wide = 32'(shifter_ff);

   // Next state and result for the presented character
   always_comb begin
      line_phase_in  = line_phase_ff;
      skip_in        = skip_ff;
      port_index_in  = port_index_ff;
      shifter_in     = shifter_ff;
      field_open_in  = field_open_ff;
      result         = '0;

      unique case (line_phase_ff)
         PH_START: begin
            if (!eol) begin
               if (char_in != CH_BAR) begin
                  line_phase_in = PH_IGNORE;
               end else if (skip_ff != '0) begin
                  skip_in       = skip_ff - 1'b1;
                  line_phase_in = PH_IGNORE;
               end else begin
                  line_phase_in = PH_DIGITS;
                  port_index_in = '0;
                  shifter_in    = '0;
                  field_open_in = 1'b0;
               end
            end
         end
         PH_IGNORE: begin
            if (eol) begin
               line_phase_in = PH_START;
            end
         end
         PH_DIGITS: begin
            if (is_digit) begin
               // frame number digits are skipped
            end else if (char_in == CH_BAR) begin
               line_phase_in = PH_FIELDS;
               shifter_in    = '0;
               field_open_in = 1'b0;
            end else begin
               line_phase_in = eol ? PH_START : PH_IGNORE;
               result.valid  = 1'b1;
               result.status = ST_BADSEP;
            end
         end
         PH_FIELDS: begin
            if (eol) begin
               line_phase_in = PH_START;
               if (field_open_ff) begin
                  field_open_in = 1'b0;
                  result.valid  = 1'b1;
                  result.status = ST_UNTERM;
                  result.port   = port_index_ff[PortOutBits-1:0];
               end
            end else if (char_in == CH_BAR) begin
               shifter_in    = '0;
               field_open_in = 1'b0;
               result.valid  = 1'b1;
               result.port   = port_index_ff[PortOutBits-1:0];
               if (over_limit) begin
                  line_phase_in = PH_IGNORE;
                  result.status = ST_PORTS;
               end else begin
                  port_index_in  = port_index_ff + 1'b1;
                  result.status  = ST_OK;
                  result.buttons = shifter_wide[ButtonOutBits-1:0];
               end
            end else begin
               field_open_in = 1'b1;
               shifter_in    = BUTTON_BITS'({shifter_ff, char_bit});
            end
         end
         default: begin
            line_phase_in = PH_START;
         end
      endcase
   end

   // State registers; a skip count write reloads the countdown
   always_ff @(posedge clock) begin
      if (reset) begin
         line_phase_ff <= PH_START;
         skip_ff       <= '0;
         port_index_ff <= '0;
         shifter_ff    <= '0;
         field_open_ff <= 1'b0;
      end else begin
         if (step) begin
            line_phase_ff <= line_phase_in;
            skip_ff       <= skip_in;
            port_index_ff <= port_index_in;
            shifter_ff    <= shifter_in;
            field_open_ff <= field_open_in;
         end
         if (skip_load) begin
            skip_ff <= skip_value;
         end
      end
   end

   // Error results never carry buttons
   assert property (@(posedge clock) disable iff (reset)
      (result.valid && result.status != ST_OK) |-> (result.buttons == '0))
      else $error("error result carries button bits");

   // A field only stays open while parsing fields
   assert property (@(posedge clock) disable iff (reset)
      field_open_ff |-> (line_phase_ff == PH_FIELDS))
      else $error("field open outside field phase");

endmodule

`default_nettype wire

>>> sv/mil_rsp_reg.sv
// Output register for result items of the movie input parser.
// Decouples the parser from a stalling receiver. Uses mil_pkg::result_type.
`default_nettype none

module mil_rsp_reg (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              step,
   input  mil_pkg::result_type                    result,
   output logic                                   slot_free,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [mil_pkg::StatusBits-1:0]         rsp_status,
   output logic [mil_pkg::PortOutBits-1:0]        rsp_port,
   output logic [mil_pkg::ButtonOutBits-1:0]      rsp_buttons
);
   import mil_pkg::*;

   logic                     valid_ff;
   logic [StatusBits-1:0]    status_ff;
   logic [PortOutBits-1:0]   port_ff;
   logic [ButtonOutBits-1:0] buttons_ff;

   // Slot may be refilled when empty or being drained this cycle
   assign slot_free = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (step) begin
         valid_ff <= result.valid;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   // Payload loads only with a new item
   always_ff @(posedge clock) begin
      if (step && result.valid) begin
         status_ff  <= result.status;
         port_ff    <= result.port;
         buttons_ff <= result.buttons;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_status  = status_ff;
   assign rsp_port    = port_ff;
   assign rsp_buttons = buttons_ff;

   // Never overwrite a result the receiver has not taken
   assert property (@(posedge clock) disable iff (reset)
      step |-> slot_free)
      else $error("step into an occupied output slot");

   // A produced result shows up in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (step && result.valid) |=> (valid_ff && status_ff == $past(result.status)))
      else $error("result not registered");

endmodule

`default_nettype wire

>>> sv/movie_input_line_parser.sv
// Movie input line parser, top level.
// Takes one text byte per item on req_, returns button words on rsp_.
// Configuration (skip count, port count) is written on csr_.
// Uses mil_pkg, mil_parser and mil_rsp_reg.
//
// Usage:
//   req_char_in carries one byte of the movie text. Each accepted item
//   updates the line parser in the cycle of acceptance; a byte that closes
//   a field (or flags an error) produces one result item, visible on rsp_
//   in the next cycle. Throughput is one item per cycle while rsp_ready is
//   high, set by the single output register: req_ready is high whenever
//   that register is empty or is being taken. Most bytes produce no result.
//   If the receiver holds rsp_ready low, the result stays in the output
//   register and req_ready drops until it is taken.
//   csr_ready is always high; csr_index 0 writes skip_records (and reloads
//   the record countdown), index 1 writes port_count, others are ignored.
//   Reset (synchronous) returns to line start, skip count 0, port count 2,
//   and empties the output register.
`default_nettype none

module movie_input_line_parser #(
   parameter int unsigned MAX_PORTS   = 4,
   parameter int unsigned BUTTON_BITS = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [mil_pkg::CharBits-1:0]       req_char_in,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [mil_pkg::StatusBits-1:0]          rsp_status,
   output logic [mil_pkg::PortOutBits-1:0]         rsp_port,
   output logic [mil_pkg::ButtonOutBits-1:0]       rsp_buttons,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [mil_pkg::CsrIndexBits-1:0]   csr_index,
   input  wire logic [mil_pkg::CsrDataBits-1:0]    csr_data
);
   import mil_pkg::*;

   logic [PortCountBits-1:0] port_count_ff;
   logic                     csr_write;
   logic                     skip_load;
   logic                     step;
   logic                     slot_free;
   result_type               result;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign req_ready = slot_free;
   assign step      = req_valid && req_ready;

   // Register decode
   always_comb begin
      skip_load = 1'b0;
      unique case (csr_index)
         CSR_SKIP_RECORDS: skip_load = csr_write;
         default: skip_load = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         port_count_ff <= PortCountBits'(2);
      end else if (csr_write && csr_index == CSR_PORT_COUNT) begin
         port_count_ff <= csr_data[PortCountBits-1:0];
      end
   end

   mil_parser #(
      .MAX_PORTS   (MAX_PORTS),
      .BUTTON_BITS (BUTTON_BITS)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .char_in    (req_char_in),
      .port_count (port_count_ff),
      .skip_load  (skip_load),
      .skip_value (csr_data[SkipBits-1:0]),
      .result     (result)
   );

   mil_rsp_reg u_rsp_reg (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .result      (result),
      .slot_free   (slot_free),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_status  (rsp_status),
      .rsp_port    (rsp_port),
      .rsp_buttons (rsp_buttons)
   );

endmodule

`default_nettype wire
